[hdl/ffca_pkg.sv]
// Shared types, constants and codes for the first-fit coalescing allocator.
`default_nettype none
package ffca_pkg;

    localparam int ARENA_UNITS  = 1024;
    localparam int UNIT_W       = $clog2(ARENA_UNITS);
    localparam int SIZE_W       = UNIT_W + 1;
    localparam int ENTRY_W      = SIZE_W + 1;
    localparam int BYTES_W      = 21;
    localparam int WANT_W       = BYTES_W + 1;
    localparam int HEADER_BYTES = 64;
    localparam int MAX_SHIFT    = 12;
    localparam int SHIFT_W      = 4;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_SHRINK = 2'd2,
        REQ_QUERY  = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_BAD   = 2'd2
    } stat_code_t;

    typedef enum logic {
        CFG_GSHIFT = 1'b0,
        CFG_ARENA  = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SIZE,
        ST_RD,
        ST_EV,
        ST_NX_RD,
        ST_NX_EV,
        ST_WR2,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [BYTES_W-1:0] size_bytes;
        logic [UNIT_W-1:0]  block_unit;
        logic               use_hint;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [UNIT_W-1:0] result_unit;
        logic [SIZE_W-1:0] result_units;
        logic [SIZE_W-1:0] free_units;
        logic              largest_known;
        logic [SIZE_W-1:0] largest_units;
    } rsp_t;

    // Table port: one write and one read address per cycle.
    typedef struct packed {
        logic               we;
        logic [UNIT_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [UNIT_W-1:0]  raddr;
    } tbl_ctl_t;

endpackage
`default_nettype wire

[hdl/ffca_table.sv]
// Block table memory: free flag and size per block start, registered read.
`default_nettype none
module ffca_table
(
    input  wire                          clk,
    input  ffca_pkg::tbl_ctl_t           ctl,
    output logic [ffca_pkg::ENTRY_W-1:0] rdata
);
    import ffca_pkg::*;

    logic [ENTRY_W-1:0] mem [ARENA_UNITS];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata <= mem[ctl.raddr];
    end

endmodule
`default_nettype wire

[hdl/ffca_engine.sv]
// Sequencer that walks the block table and carries out each request.
`default_nettype none
module ffca_engine
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  ffca_pkg::req_t               req,
    output logic                         done,
    output ffca_pkg::rsp_t               rsp,
    input  wire                          init_req,
    input  wire  [ffca_pkg::SIZE_W-1:0]  arena_n,
    input  wire  [ffca_pkg::SHIFT_W-1:0] gshift,
    output ffca_pkg::tbl_ctl_t           tbl,
    input  wire  [ffca_pkg::ENTRY_W-1:0] rdata
);
    import ffca_pkg::*;

    st_t                state_reg, state_next;
    req_t               req_reg, req_next;
    logic [WANT_W-1:0]  want_reg, want_next;
    logic [SIZE_W-1:0]  p_reg, p_next;
    logic               locating_reg, locating_next;
    logic               nx_ok_reg, nx_ok_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [UNIT_W-1:0]  prev_unit_reg, prev_unit_next;
    logic               prev_free_reg, prev_free_next;
    logic [SIZE_W-1:0]  prev_size_reg, prev_size_next;
    logic [SIZE_W-1:0]  cur_size_reg, cur_size_next;
    logic               best_valid_reg, best_valid_next;
    logic [UNIT_W-1:0]  best_unit_reg, best_unit_next;
    logic [SIZE_W-1:0]  best_size_reg, best_size_next;
    logic [SIZE_W-1:0]  free_total_reg, free_total_next;
    logic               lg_valid_reg, lg_valid_next;
    logic               lg_present_reg, lg_present_next;
    logic [UNIT_W-1:0]  lg_start_reg, lg_start_next;
    logic [SIZE_W-1:0]  lg_size_reg, lg_size_next;
    logic [1:0]         stat_reg, stat_next;
    logic [UNIT_W-1:0]  r_unit_reg, r_unit_next;
    logic [SIZE_W-1:0]  r_units_reg, r_units_next;
    logic [UNIT_W-1:0]  wr2_addr_reg, wr2_addr_next;
    logic [ENTRY_W-1:0] wr2_data_reg, wr2_data_next;

    logic               e_free;
    logic [SIZE_W-1:0]  e_size;
    logic [SIZE_W:0]    p_adv;
    logic [SIZE_W-1:0]  nxs;
    logic [SIZE_W-1:0]  merged;
    logic [UNIT_W-1:0]  mstart;
    logic [SIZE_W-1:0]  rec_size;
    logic [SIZE_W-1:0]  nu;
    logic [SIZE_W-1:0]  diff;
    logic [WANT_W-1:0]  gmask;
    logic [WANT_W-1:0]  add_term;
    logic               is_unit;

    assign e_free   = rdata[ENTRY_W-1];
    assign e_size   = rdata[SIZE_W-1:0];
    assign p_adv    = {1'b0, p_reg} + {1'b0, e_size};
    assign rec_size = (lg_valid_reg && lg_present_reg) ? lg_size_reg : '0;
    assign nxs      = (nx_ok_reg && e_free) ? e_size : '0;
    assign nu       = want_reg[SIZE_W-1:0];
    assign diff     = cur_size_reg - nu;
    assign is_unit  = (p_reg == {1'b0, req_reg.block_unit});
    assign gmask    = (WANT_W'(1) << gshift) - WANT_W'(1);
    assign add_term = (req_reg.req_type == REQ_ALLOC) ? gmask + WANT_W'(HEADER_BYTES) : gmask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            req_reg        <= '0;
            want_reg       <= '0;
            p_reg          <= '0;
            locating_reg   <= 1'b0;
            nx_ok_reg      <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_unit_reg  <= '0;
            prev_free_reg  <= 1'b0;
            prev_size_reg  <= '0;
            cur_size_reg   <= '0;
            best_valid_reg <= 1'b0;
            best_unit_reg  <= '0;
            best_size_reg  <= '0;
            free_total_reg <= '0;
            lg_valid_reg   <= 1'b0;
            lg_present_reg <= 1'b0;
            lg_start_reg   <= '0;
            lg_size_reg    <= '0;
            stat_reg       <= STAT_OK;
            r_unit_reg     <= '0;
            r_units_reg    <= '0;
            wr2_addr_reg   <= '0;
            wr2_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            want_reg       <= want_next;
            p_reg          <= p_next;
            locating_reg   <= locating_next;
            nx_ok_reg      <= nx_ok_next;
            prev_valid_reg <= prev_valid_next;
            prev_unit_reg  <= prev_unit_next;
            prev_free_reg  <= prev_free_next;
            prev_size_reg  <= prev_size_next;
            cur_size_reg   <= cur_size_next;
            best_valid_reg <= best_valid_next;
            best_unit_reg  <= best_unit_next;
            best_size_reg  <= best_size_next;
            free_total_reg <= free_total_next;
            lg_valid_reg   <= lg_valid_next;
            lg_present_reg <= lg_present_next;
            lg_start_reg   <= lg_start_next;
            lg_size_reg    <= lg_size_next;
            stat_reg       <= stat_next;
            r_unit_reg     <= r_unit_next;
            r_units_reg    <= r_units_next;
            wr2_addr_reg   <= wr2_addr_next;
            wr2_data_reg   <= wr2_data_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        want_next       = want_reg;
        p_next          = p_reg;
        locating_next   = locating_reg;
        nx_ok_next      = nx_ok_reg;
        prev_valid_next = prev_valid_reg;
        prev_unit_next  = prev_unit_reg;
        prev_free_next  = prev_free_reg;
        prev_size_next  = prev_size_reg;
        cur_size_next   = cur_size_reg;
        best_valid_next = best_valid_reg;
        best_unit_next  = best_unit_reg;
        best_size_next  = best_size_reg;
        free_total_next = free_total_reg;
        lg_valid_next   = lg_valid_reg;
        lg_present_next = lg_present_reg;
        lg_start_next   = lg_start_reg;
        lg_size_next    = lg_size_reg;
        stat_next       = stat_reg;
        r_unit_next     = r_unit_reg;
        r_units_next    = r_units_reg;
        wr2_addr_next   = wr2_addr_reg;
        wr2_data_next   = wr2_data_reg;
        merged          = '0;
        mstart          = '0;
        tbl.we          = 1'b0;
        tbl.waddr       = '0;
        tbl.wdata       = '0;
        tbl.raddr       = p_reg[UNIT_W-1:0];
        done            = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                // Lay down one free block over the whole arena.
                tbl.we          = 1'b1;
                tbl.waddr       = '0;
                tbl.wdata       = {1'b1, arena_n};
                free_total_next = arena_n;
                lg_valid_next   = 1'b0;
                lg_present_next = 1'b0;
                lg_start_next   = '0;
                lg_size_next    = '0;
                // Repeat when the arena size changes under us.
                if (init_req)
                begin
                    state_next = ST_INIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (init_req)
                begin
                    state_next = ST_INIT;
                end
                else if (start)
                begin
                    req_next        = req;
                    prev_valid_next = 1'b0;
                    best_valid_next = 1'b0;
                    best_size_next  = '0;
                    stat_next       = STAT_OK;
                    r_unit_next     = '0;
                    r_units_next    = '0;
                    p_next          = '0;
                    state_next      = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                // Shared shifter: granules needed, header included for allocate.
                want_next     = ({1'b0, req_reg.size_bytes} + add_term) >> gshift;
                locating_next = (req_reg.req_type != REQ_ALLOC) || req_reg.use_hint;
                if (req_reg.req_type == REQ_QUERY)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EV;
            end
            ST_EV:
            begin
                if (locating_reg)
                begin
                    if (is_unit)
                    begin
                        cur_size_next = e_size;
                        nx_ok_next    = (p_adv < {1'b0, arena_n});
                        if (req_reg.req_type == REQ_ALLOC)
                        begin
                            if (!e_free)
                            begin
                                stat_next  = STAT_BAD;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                locating_next = 1'b0;
                                state_next    = ST_RD;
                            end
                        end
                        else if (e_free)
                        begin
                            stat_next  = STAT_BAD;
                            state_next = ST_DONE;
                        end
                        else if (req_reg.req_type == REQ_SHRINK &&
                                 (req_reg.size_bytes < BYTES_W'(HEADER_BYTES) ||
                                  want_reg > {{(WANT_W-SIZE_W){1'b0}}, e_size}))
                        begin
                            stat_next  = STAT_BAD;
                            state_next = ST_DONE;
                        end
                        else if (req_reg.req_type == REQ_SHRINK &&
                                 want_reg == {{(WANT_W-SIZE_W){1'b0}}, e_size})
                        begin
                            r_unit_next  = req_reg.block_unit;
                            r_units_next = nu;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            p_next = p_adv[SIZE_W-1:0];
                            if (p_adv < {1'b0, arena_n})
                            begin
                                state_next = ST_NX_RD;
                            end
                            else
                            begin
                                state_next = ST_NX_EV;
                            end
                        end
                    end
                    else if (e_size == '0 || p_adv >= {1'b0, arena_n})
                    begin
                        stat_next  = STAT_BAD;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        prev_valid_next = 1'b1;
                        prev_unit_next  = p_reg[UNIT_W-1:0];
                        prev_free_next  = e_free;
                        prev_size_next  = e_size;
                        p_next          = p_adv[SIZE_W-1:0];
                        state_next      = ST_RD;
                    end
                end
                else if (e_size != '0 && e_free &&
                         {{(WANT_W-SIZE_W){1'b0}}, e_size} >= want_reg)
                begin
                    // Fit: carve the front, split the remainder off as free.
                    tbl.we          = 1'b1;
                    tbl.waddr       = p_reg[UNIT_W-1:0];
                    tbl.wdata       = {1'b0, nu};
                    free_total_next = free_total_reg - nu;
                    if (lg_valid_reg && lg_present_reg &&
                        lg_start_reg == p_reg[UNIT_W-1:0])
                    begin
                        lg_valid_next   = 1'b0;
                        lg_present_next = 1'b0;
                        lg_start_next   = '0;
                        lg_size_next    = '0;
                    end
                    r_unit_next   = p_reg[UNIT_W-1:0];
                    r_units_next  = nu;
                    wr2_addr_next = p_reg[UNIT_W-1:0] + nu[UNIT_W-1:0];
                    wr2_data_next = {1'b1, e_size - nu};
                    if (e_size > nu)
                    begin
                        state_next = ST_WR2;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    if (e_free && !req_reg.use_hint &&
                        (!best_valid_reg || e_size > best_size_reg))
                    begin
                        best_valid_next = 1'b1;
                        best_unit_next  = p_reg[UNIT_W-1:0];
                        best_size_next  = e_size;
                    end
                    if (e_size == '0 || p_adv >= {1'b0, arena_n})
                    begin
                        stat_next  = STAT_NOFIT;
                        state_next = ST_DONE;
                        if (!req_reg.use_hint)
                        begin
                            lg_valid_next = 1'b1;
                            if (e_free && (!best_valid_reg || e_size > best_size_reg))
                            begin
                                lg_present_next = 1'b1;
                                lg_start_next   = p_reg[UNIT_W-1:0];
                                lg_size_next    = e_size;
                            end
                            else
                            begin
                                lg_present_next = best_valid_reg;
                                lg_start_next   = best_valid_reg ? best_unit_reg : '0;
                                lg_size_next    = best_size_reg;
                            end
                        end
                    end
                    else
                    begin
                        p_next     = p_adv[SIZE_W-1:0];
                        state_next = ST_RD;
                    end
                end
            end
            ST_NX_RD:
            begin
                state_next = ST_NX_EV;
            end
            ST_NX_EV:
            begin
                if (req_reg.req_type == REQ_FREE)
                begin
                    if (prev_valid_reg && prev_free_reg)
                    begin
                        mstart = prev_unit_reg;
                        merged = cur_size_reg + nxs + prev_size_reg;
                    end
                    else
                    begin
                        mstart = req_reg.block_unit;
                        merged = cur_size_reg + nxs;
                    end
                    tbl.we          = 1'b1;
                    tbl.waddr       = mstart;
                    tbl.wdata       = {1'b1, merged};
                    free_total_next = free_total_reg + cur_size_reg;
                    r_unit_next     = mstart;
                    r_units_next    = merged;
                    state_next      = ST_DONE;
                end
                else
                begin
                    mstart          = req_reg.block_unit + nu[UNIT_W-1:0];
                    merged          = diff + nxs;
                    tbl.we          = 1'b1;
                    tbl.waddr       = req_reg.block_unit;
                    tbl.wdata       = {1'b0, nu};
                    wr2_addr_next   = mstart;
                    wr2_data_next   = {1'b1, merged};
                    free_total_next = free_total_reg + diff;
                    r_unit_next     = req_reg.block_unit;
                    r_units_next    = nu;
                    state_next      = ST_WR2;
                end
                if (lg_valid_reg && merged > rec_size)
                begin
                    lg_present_next = 1'b1;
                    lg_start_next   = mstart;
                    lg_size_next    = merged;
                end
            end
            ST_WR2:
            begin
                tbl.we     = 1'b1;
                tbl.waddr  = wr2_addr_reg;
                tbl.wdata  = wr2_data_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done = 1'b1;
                if (init_req)
                begin
                    state_next = ST_INIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy              = (state_reg != ST_IDLE);
    assign rsp.status        = stat_reg;
    assign rsp.result_unit   = r_unit_reg;
    assign rsp.result_units  = r_units_reg;
    assign rsp.free_units    = free_total_reg;
    assign rsp.largest_known = lg_valid_reg;
    assign rsp.largest_units = rec_size;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (free_total_reg <= arena_n))
        else $error("free total exceeds arena size");
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STAT_OK) |-> (rsp.result_units == '0))
        else $error("failed request reports a block");
    a_rec_known: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.largest_known) |-> (rsp.largest_units == '0))
        else $error("largest size reported while record invalid");

endmodule
`default_nettype wire

[hdl/first_fit_coalescing_allocator.sv]
// Top level of the first-fit coalescing allocator: configuration and wiring.
`default_nettype none
// Usage
//   Request channel: drive req and pulse start while busy is low; the request
//   is taken at that edge and busy rises for the rest of its work.
//   Result channel: done is high for exactly one cycle with rsp valid; the
//   receiver must take it then, as it cannot stall the block.
//   Configuration: cfg_we with cfg_idx and cfg_data writes a register. Index 0
//   is the granule shift (low four bits used, values above 12 held at 12);
//   index 1 is the arena size, and writing it while the engine is idle or at
//   done re-forms the arena as one free block, with busy high meanwhile.
// Operation
//   Each allocate, free or shrink request walks the block table from the
//   lowest block, a table read and then an evaluate for each block visited,
//   because the table read is registered and an entry arrives the cycle after
//   its address. Free and shrink may then read the next block and write back;
//   an allocate writes the carved block and any split remainder. A query does not walk the table.
//   One request is in flight at a time; the next is taken after done.
// Reset
//   After rst_n is released the block writes the single free block, with
//   busy high, then accepts requests.
module first_fit_coalescing_allocator
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  ffca_pkg::req_t                req,
    output logic                          done,
    output ffca_pkg::rsp_t                rsp,
    input  wire                           cfg_we,
    input  wire                           cfg_idx,
    input  wire  [ffca_pkg::SIZE_W-1:0]   cfg_data
);
    import ffca_pkg::*;

    logic [SHIFT_W-1:0] gshift_reg, gshift_next;
    logic [SIZE_W-1:0]  arena_reg, arena_next;
    logic [SIZE_W-1:0]  arena_n;
    logic               init_req;
    tbl_ctl_t           tbl;
    logic [ENTRY_W-1:0] rdata;

    // Clamp the shift on write so the sizing shifter never sees more than 12.
    always_comb
    begin
        gshift_next = gshift_reg;
        arena_next  = arena_reg;
        if (cfg_we && cfg_idx == CFG_GSHIFT)
        begin
            if (cfg_data[SHIFT_W-1:0] > SHIFT_W'(MAX_SHIFT))
            begin
                gshift_next = SHIFT_W'(MAX_SHIFT);
            end
            else
            begin
                gshift_next = cfg_data[SHIFT_W-1:0];
            end
        end
        if (cfg_we && cfg_idx == CFG_ARENA)
        begin
            arena_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gshift_reg <= SHIFT_W'(6);
            arena_reg  <= SIZE_W'(ARENA_UNITS);
        end
        else
        begin
            gshift_reg <= gshift_next;
            arena_reg  <= arena_next;
        end
    end

    // Hold the arena size within one granule and the table depth.
    assign arena_n  = (arena_reg == '0) ? SIZE_W'(1) :
                      (arena_reg > SIZE_W'(ARENA_UNITS)) ? SIZE_W'(ARENA_UNITS) : arena_reg;
    assign init_req = cfg_we && (cfg_idx == CFG_ARENA);

    ffca_table u_table
    (
        .clk   (clk),
        .ctl   (tbl),
        .rdata (rdata)
    );

    ffca_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .init_req (init_req),
        .arena_n  (arena_n),
        .gshift   (gshift_reg),
        .tbl      (tbl),
        .rdata    (rdata)
    );

endmodule
`default_nettype wire
